### sv/wbps_pkg.sv
// types and constants shared by the wildcard byte pattern scanner
// no dependencies; compiled before the interfaces and modules
package wbps_pkg;

   localparam int AddrWidth   = 64;
   localparam int WordWidth   = 64;
   localparam int PatWords    = 4;
   localparam int MaskWidth   = 32;
   localparam int LenWidth    = 6;
   localparam int CsrIdxWidth = 4;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_PATTERN_WORD0 = 4'd0,
      CSR_PATTERN_WORD1 = 4'd1,
      CSR_PATTERN_WORD2 = 4'd2,
      CSR_PATTERN_WORD3 = 4'd3,
      CSR_WILDCARD_MASK = 4'd4,
      CSR_PATTERN_LEN   = 4'd5,
      CSR_REPORT_END    = 4'd6,
      CSR_REGION_BASE   = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [PatWords-1:0][WordWidth-1:0] pattern_words;
      logic [MaskWidth-1:0]               wildcard_mask;
      logic [LenWidth-1:0]                pattern_length;
      logic                               report_end;
      logic [AddrWidth-1:0]               region_base;
   } cfg_type;

endpackage

### sv/wbps_req_if.sv
// request channel of the scanner: one region byte per item
// depends on nothing
interface wbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### sv/wbps_rsp_if.sv
// result channel of the scanner: found flag and match address
// depends on nothing
interface wbps_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [63:0] match_address;

   modport source (output valid, output found, output match_address, input ready);
   modport sink   (input valid, input found, input match_address, output ready);
endinterface

### sv/wbps_csr.sv
// configuration registers of the scanner, written through a plain write port
// depends on wbps_pkg
module wbps_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [wbps_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [wbps_pkg::WordWidth-1:0]      csr_write_data,
   output wbps_pkg::cfg_type                   cfg
);

   wbps_pkg::cfg_type cfg_ff;
   wbps_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (wbps_pkg::csr_index_type'(csr_index))
            wbps_pkg::CSR_PATTERN_WORD0: cfg_in.pattern_words[0] = csr_write_data;
            wbps_pkg::CSR_PATTERN_WORD1: cfg_in.pattern_words[1] = csr_write_data;
            wbps_pkg::CSR_PATTERN_WORD2: cfg_in.pattern_words[2] = csr_write_data;
            wbps_pkg::CSR_PATTERN_WORD3: cfg_in.pattern_words[3] = csr_write_data;
            wbps_pkg::CSR_WILDCARD_MASK:
               cfg_in.wildcard_mask = csr_write_data[wbps_pkg::MaskWidth-1:0];
            wbps_pkg::CSR_PATTERN_LEN:
               cfg_in.pattern_length = csr_write_data[wbps_pkg::LenWidth-1:0];
            wbps_pkg::CSR_REPORT_END:  cfg_in.report_end = csr_write_data[0];
            wbps_pkg::CSR_REGION_BASE: cfg_in.region_base = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{pattern_words:  '0,
                     wildcard_mask:  '0,
                     pattern_length: wbps_pkg::LenWidth'(1),
                     report_end:     1'b0,
                     region_base:    '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/wbps_match.sv
// masked compare of the byte window against the configured pattern
// depends on wbps_pkg
module wbps_match #(
   parameter int MAX_PATTERN_BYTES = 32
) (
   input  logic [7:0]                    window [MAX_PATTERN_BYTES],
   input  wbps_pkg::cfg_type             cfg,
   input  logic [wbps_pkg::LenWidth-1:0] len_m1,
   output logic                          hit
);

   localparam int WinIdxWidth = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

   logic [wbps_pkg::PatWords*wbps_pkg::WordWidth-1:0] pattern_flat;

   assign pattern_flat = cfg.pattern_words;

   // pattern byte i lines up with window entry len-1-i (entry 0 is the newest byte)
   always_comb begin
      logic [wbps_pkg::LenWidth-1:0] pos;
      logic                          ok;
      hit = 1'b1;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         pos = len_m1 - wbps_pkg::LenWidth'(i);
         ok  = (wbps_pkg::LenWidth'(i) > len_m1) || cfg.wildcard_mask[i]
               || (window[pos[WinIdxWidth-1:0]] == pattern_flat[8*i +: 8]);
         hit = hit & ok;
      end
   end

endmodule

### sv/wildcard_byte_pattern_scanner_unit.sv
// wildcard byte pattern scanner, top level
// an accepted item loads the window register; the result of its compare is registered
// in the result register when the item retires, which rsp_ch back-pressure can delay
// throughput: one byte per cycle while rsp_ch is ready; the window register feeds the
// masked compare and address add, which load the result register
// reset (synchronous, active high) clears handshake state, region tracking and
// all configuration registers to their defaults; no clearing pass is needed
module wildcard_byte_pattern_scanner_unit #(
   parameter int MAX_PATTERN_BYTES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   wbps_req_if.sink                            req_ch,
   wbps_rsp_if.source                          rsp_ch,
   input  logic                                csr_write_enable,
   input  logic [wbps_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [wbps_pkg::WordWidth-1:0]      csr_write_data
);

   localparam int LW = wbps_pkg::LenWidth;
   localparam int AW = wbps_pkg::AddrWidth;

   wbps_pkg::cfg_type cfg;

   // window stage: holds the newest item and its offset in the region
   logic [7:0]    window_ff [MAX_PATTERN_BYTES];
   logic [7:0]    window_in [MAX_PATTERN_BYTES];
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_last_ff;
   logic [AW-1:0] cur_ff, cur_in;
   logic          start_ff, start_in;
   logic          reported_ff, reported_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          found_ff;
   logic [AW-1:0] addr_ff;

   logic          accept, out_free, retire, emit, hit, hit_qual;
   logic [LW-1:0] len_eff, len_m1;
   logic [AW-1:0] addr_adj, addr;

   wbps_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // length 0 counts as 1, and anything above the window depth saturates
   always_comb begin
      if (cfg.pattern_length == '0) begin
         len_eff = LW'(1);
      end else if (cfg.pattern_length > LW'(MAX_PATTERN_BYTES)) begin
         len_eff = LW'(MAX_PATTERN_BYTES);
      end else begin
         len_eff = cfg.pattern_length;
      end
   end

   assign len_m1 = len_eff - LW'(1);

   wbps_match #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
   ) u_match (
      .window (window_ff),
      .cfg    (cfg),
      .len_m1 (len_m1),
      .hit    (hit)
   );

   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = !s1_valid_ff || out_free;
   assign accept        = req_ch.valid && req_ch.ready;
   assign retire        = s1_valid_ff && out_free;

   assign hit_qual = hit && (cur_ff >= AW'(len_m1)) && !reported_ff;
   assign emit     = retire && !reported_ff && (hit_qual || s1_last_ff);

   assign addr_adj = cfg.report_end ? AW'(1) : (AW'(0) - AW'(len_m1));
   assign addr     = cfg.region_base + cur_ff + addr_adj;

   always_comb begin
      window_in    = window_ff;
      cur_in       = cur_ff;
      start_in     = start_ff;
      s1_valid_in  = s1_valid_ff;
      reported_in  = reported_ff;
      rsp_valid_in = rsp_valid_ff;

      if (retire) begin
         s1_valid_in = 1'b0;
         reported_in = s1_last_ff ? 1'b0 : (reported_ff || hit_qual);
      end
      if (accept) begin
         // bytes older than the region start are never compared, so no clear
         window_in[0] = req_ch.data_byte;
         for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
            window_in[i] = window_ff[i-1];
         end
         cur_in      = start_ff ? '0 : cur_ff + AW'(1);
         start_in    = req_ch.last_byte;
         s1_valid_in = 1'b1;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         start_ff     <= 1'b1;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         start_ff     <= start_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      cur_ff    <= cur_in;
      if (accept) begin
         s1_last_ff <= req_ch.last_byte;
      end
      if (emit) begin
         found_ff <= hit_qual;
         addr_ff  <= hit_qual ? addr : '0;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.found         = found_ff;
   assign rsp_ch.match_address = addr_ff;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the wildcard byte pattern scanner: directed regions, then random
// regions under several pattern settings; needs wbps_pkg, both channel interfaces and the top
module testbench;

   localparam int MaxPattern     = 32;
   localparam int FirstUnusedCsr = 8;
   localparam int LastCsr        = (1 << wbps_pkg::CsrIdxWidth) - 1;
   localparam int PhaseBytes     = 190;
   localparam int DrainCycles    = 8;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } region_byte_type;

   typedef struct packed {
      logic                           found;
      logic [wbps_pkg::AddrWidth-1:0] match_address;
   } scan_result_type;

   logic clock;
   logic reset;
   logic                             csr_write_enable;
   logic [wbps_pkg::CsrIdxWidth-1:0] csr_index;
   logic [wbps_pkg::WordWidth-1:0]   csr_write_data;

   wbps_req_if req_if();
   wbps_rsp_if rsp_if();

   wildcard_byte_pattern_scanner_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   region_byte_type pending_bytes[$];
   scan_result_type expected_results[$];
   scan_result_type oldest;
   int  bytes_queued;
   int  mismatches;
   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_off;
   bit  req_taken;

   // scanner state as the bench sees it
   wbps_pkg::cfg_type              scan_cfg;
   logic [7:0]                     recent_bytes [MaxPattern];
   logic [wbps_pkg::AddrWidth-1:0] region_offset;
   bit                             region_matched;

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int unsigned active_length();
      int unsigned n;
      n = scan_cfg.pattern_length;
      if (n == 0) n = 1;
      if (n > MaxPattern) n = MaxPattern;
      return n;
   endfunction

   function automatic logic [7:0] pattern_byte_at(int unsigned i);
      return scan_cfg.pattern_words[i / 8][(i % 8) * 8 +: 8];
   endfunction

   task automatic clear_region_state();
      for (int k = 0; k < MaxPattern; k++) recent_bytes[k] = 8'h00;
      region_offset  = '0;
      region_matched = 1'b0;
   endtask

   task automatic predict_scan(input logic [7:0] b, input logic last);
      int unsigned len;
      bit hit;
      scan_result_type r;
      hit = 1'b0;
      if (!region_matched) begin
         len = active_length();
         for (int k = MaxPattern - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k - 1];
         recent_bytes[0] = b;
         if (region_offset >= wbps_pkg::AddrWidth'(len - 1)) begin
            hit = 1'b1;
            for (int unsigned i = 0; i < len; i++) begin
               if (!scan_cfg.wildcard_mask[i] && recent_bytes[len - 1 - i] != pattern_byte_at(i))
                  hit = 1'b0;
            end
            if (hit) begin
               r.found = 1'b1;
               if (scan_cfg.report_end)
                  r.match_address = scan_cfg.region_base + region_offset + 1;
               else
                  r.match_address = scan_cfg.region_base + region_offset
                                    - wbps_pkg::AddrWidth'(len - 1);
               expected_results.push_back(r);
               region_matched = 1'b1;
            end
         end
         region_offset = region_offset + 1;
         if (!hit && last) begin
            r.found         = 1'b0;
            r.match_address = '0;
            expected_results.push_back(r);
         end
      end
      if (last) clear_region_state();
   endtask

   task automatic write_csr(input logic [wbps_pkg::CsrIdxWidth-1:0] idx,
                            input logic [wbps_pkg::WordWidth-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         wbps_pkg::CSR_PATTERN_WORD0: scan_cfg.pattern_words[0] = data;
         wbps_pkg::CSR_PATTERN_WORD1: scan_cfg.pattern_words[1] = data;
         wbps_pkg::CSR_PATTERN_WORD2: scan_cfg.pattern_words[2] = data;
         wbps_pkg::CSR_PATTERN_WORD3: scan_cfg.pattern_words[3] = data;
         wbps_pkg::CSR_WILDCARD_MASK:
            scan_cfg.wildcard_mask  = data[wbps_pkg::MaskWidth-1:0];
         wbps_pkg::CSR_PATTERN_LEN:
            scan_cfg.pattern_length = data[wbps_pkg::LenWidth-1:0];
         wbps_pkg::CSR_REPORT_END:    scan_cfg.report_end  = data[0];
         wbps_pkg::CSR_REGION_BASE:   scan_cfg.region_base = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic push_byte(input logic [7:0] b, input logic last);
      region_byte_type item;
      item.data_byte = b;
      item.last_byte = last;
      pending_bytes.push_back(item);
      bytes_queued++;
   endtask

   // block idle: everything sent, every result back, pipeline given time to settle
   task automatic wait_drained();
      while (pending_bytes.size() != 0 || expected_results.size() != 0 || req_if.valid)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic configure_phase(input int p);
      logic [wbps_pkg::MaskWidth-1:0] mask;
      logic [wbps_pkg::LenWidth-1:0]  len;
      logic [wbps_pkg::WordWidth-1:0] base;
      for (int w = 0; w < wbps_pkg::PatWords; w++) begin
         if (p == 3)
            write_csr(wbps_pkg::CsrIdxWidth'(wbps_pkg::CSR_PATTERN_WORD0 + w), '1);
         else
            write_csr(wbps_pkg::CsrIdxWidth'(wbps_pkg::CSR_PATTERN_WORD0 + w),
                      {$urandom, $urandom});
      end
      case (p)
         0:       begin mask = '0;              len = 6'd1;  base = '0; end
         1:       begin mask = $urandom & $urandom & $urandom;
                        len = 6'd32; base = '1; end
         2:       begin mask = '1;              len = 6'd0;  base = {$urandom, $urandom}; end
         3:       begin mask = '0;              len = 6'd63; base = {$urandom, $urandom}; end
         4:       begin mask = $urandom & $urandom; len = 6'($urandom_range(31, 9));
                        base = {$urandom, $urandom}; end
         default: begin mask = $urandom & $urandom; len = 6'($urandom_range(8, 2));
                        base = {$urandom, $urandom}; end
      endcase
      // upper data bits beyond each register's width must be dropped
      write_csr(wbps_pkg::CSR_WILDCARD_MASK, {$urandom, mask});
      write_csr(wbps_pkg::CSR_PATTERN_LEN, {$urandom, 26'($urandom), len});
      write_csr(wbps_pkg::CSR_REPORT_END, {$urandom, 31'($urandom), 1'(p % 2)});
      write_csr(wbps_pkg::CSR_REGION_BASE, base);
      write_csr(wbps_pkg::CsrIdxWidth'($urandom_range(LastCsr, FirstUnusedCsr)),
                {$urandom, $urandom});
   endtask

   task automatic queue_random_region();
      int unsigned len, kind, lead, tail, part, n;
      logic [7:0] inst [MaxPattern];
      len = active_length();
      for (int unsigned i = 0; i < len; i++)
         inst[i] = scan_cfg.wildcard_mask[i] ? 8'($urandom) : pattern_byte_at(i);
      kind = $urandom_range(99);
      if (kind < 65) begin
         lead = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(6);
         repeat (lead) push_byte(8'($urandom), 1'b0);
         // broken start of the pattern just ahead of the real one
         if (len > 1 && $urandom_range(1)) begin
            part = $urandom_range(len - 1, 1);
            for (int unsigned i = 0; i < part; i++) push_byte(inst[i], 1'b0);
            if (!scan_cfg.wildcard_mask[part])
               push_byte(pattern_byte_at(part) ^ 8'($urandom_range(255, 1)), 1'b0);
         end
         tail = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 1);
         for (int unsigned i = 0; i < len; i++)
            push_byte(inst[i], (tail == 0) && (i == len - 1));
         if (tail > 0) begin
            repeat (tail - 1) push_byte(8'($urandom), 1'b0);
            push_byte(8'($urandom), 1'b1);
         end
      end else begin
         // region too short for the pattern, or plain noise
         if (kind < 80)
            n = (len > 1) ? $urandom_range(len - 1, 1) : 1;
         else
            n = $urandom_range(40, 1);
         for (int unsigned i = 0; i < n; i++) push_byte(8'($urandom), i == n - 1);
      end
   endtask

   // accepted items and results, sampled at the rising edge
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: found %0d match_address %h",
                      rsp_if.found, rsp_if.match_address);
               mismatches++;
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_if.found !== oldest.found) begin
                  $error("found: expected %0d, actual %0d", oldest.found, rsp_if.found);
                  mismatches++;
               end
               if (rsp_if.match_address !== oldest.match_address) begin
                  $error("match_address: expected %h, actual %h",
                         oldest.match_address, rsp_if.match_address);
                  mismatches++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            req_taken = 1'b1;
            predict_scan(req_if.data_byte, req_if.last_byte);
            void'(pending_bytes.pop_front());
         end
      end
   end

   // request driver and result back-pressure, changed at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (!req_if.valid || req_taken) begin
            if (hold_off || pending_bytes.size() == 0 || $urandom_range(99) < send_idle_pct) begin
               req_if.valid <= 1'b0;
            end else begin
               req_if.valid     <= 1'b1;
               req_if.data_byte <= pending_bytes[0].data_byte;
               req_if.last_byte <= pending_bytes[0].last_byte;
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      int start;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_if.valid     = 1'b0;
      req_if.data_byte = 8'h00;
      req_if.last_byte = 1'b0;
      rsp_if.ready     = 1'b0;
      hold_off         = 1'b0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      bytes_queued     = 0;
      mismatches       = 0;
      scan_cfg         = '0;
      scan_cfg.pattern_length = 6'd1;
      clear_region_state();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset pattern is a single zero byte: match at once, then a last byte to be ignored
      push_byte(8'h00, 1'b0);
      push_byte(8'h5a, 1'b1);
      push_byte(8'hff, 1'b1);
      wait_drained();

      write_csr(wbps_pkg::CSR_PATTERN_WORD0, 64'h0000_0000_4342_4141);
      write_csr(wbps_pkg::CSR_PATTERN_LEN, 64'd4);
      write_csr(wbps_pkg::CSR_REPORT_END, 64'd1);
      write_csr(wbps_pkg::CSR_REGION_BASE, '1);
      write_csr(wbps_pkg::CsrIdxWidth'($urandom_range(LastCsr, FirstUnusedCsr)),
                {$urandom, $urandom});
      // restart must retest the byte that broke the partial match; match on last byte
      push_byte(8'h41, 1'b0);
      push_byte(8'h41, 1'b0);
      push_byte(8'h41, 1'b0);
      push_byte(8'h42, 1'b0);
      push_byte(8'h43, 1'b1);
      // too short for the pattern
      push_byte(8'h41, 1'b0);
      push_byte(8'h42, 1'b1);
      // region left open while the settings change under it
      push_byte(8'h00, 1'b0);
      push_byte(8'h41, 1'b0);
      push_byte(8'h41, 1'b0);
      push_byte(8'h42, 1'b0);
      wait_drained();
      write_csr(wbps_pkg::CSR_WILDCARD_MASK, 64'h8);
      write_csr(wbps_pkg::CSR_REPORT_END, 64'd0);
      push_byte(8'h7e, 1'b1);
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         configure_phase(phase);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         start = bytes_queued;
         while (bytes_queued - start < PhaseBytes) queue_random_region();
         if (phase == 2 || phase == 6) begin
            // sender holds off mid-phase until every outstanding result is back
            while (pending_bytes.size() > PhaseBytes / 2) @(posedge clock);
            hold_off = 1'b1;
            while (expected_results.size() != 0 || req_if.valid) @(posedge clock);
            hold_off = 1'b0;
         end
         wait_drained();
      end

      if (mismatches == 0 && expected_results.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
